/* rtl/core/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Entry layout, chain control word, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int SLOTS    = 16;
  localparam int FIRE_MAX = 16;
  localparam int FQ_AW    = $clog2(FIRE_MAX);
  localparam int FQ_CW    = $clog2(FIRE_MAX + 1);

  // input commands
  localparam logic [1:0] CMD_ONESHOT  = 2'd0;
  localparam logic [1:0] CMD_PERIODIC = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // result status
  localparam logic [2:0] ST_SETUP    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FIRED    = 3'd4;
  localparam logic [2:0] ST_QUIET    = 3'd5;

  // chain operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [31:0] expiry;
    logic [23:0] period;
    logic        periodic;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        head;   // remove slot 0 regardless of id
    logic [15:0] key;
    entry_t      ent;
  } chain_ctrl_t;

  // serial time compare: a is earlier than b
  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/stq_if.sv */
// ----------------------------------------------------------------------------
// stq_in_if / stq_out_if: command and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [23:0] delay;
  logic [23:0] interval;
  logic [15:0] cancel_id;
  modport source (output valid, command, delay, interval, cancel_id, input ready);
  modport sink   (input valid, command, delay, interval, cancel_id, output ready);
endinterface

interface stq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] timer_id;
  logic        last;
  modport source (output valid, status, timer_id, last, input ready);
  modport sink   (input valid, status, timer_id, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/stq_cell.sv */
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted timer chain
// Holds one entry; on insert or remove it keeps, takes the new entry or
// takes a neighbor's entry, decided by the position flag from the left and its own position test.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell
  import stq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire chain_ctrl_t ctrl,
  input  wire entry_t      left_ent,
  input  wire entry_t      right_ent,
  input  wire logic        found_in,
  output logic             found_out,
  output entry_t           ent_q
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   hit;

  // position test for this slot
  always_comb begin
    hit = 1'b0;
    unique case (ctrl.op)
      OP_INS:  hit = !ent_r.valid || earlier(ctrl.ent.expiry, ent_r.expiry);
      OP_REM:  hit = ctrl.head || (ent_r.valid && (ent_r.id == ctrl.key));
      default: hit = 1'b0;
    endcase
  end

  assign found_out = found_in | hit;

  // shift right on insert, left on remove
  always_comb begin
    ent_nxt = ent_r;
    unique case (ctrl.op)
      OP_INS: begin
        if (found_in) ent_nxt = left_ent;
        else if (hit) ent_nxt = ctrl.ent;
      end
      OP_REM: begin
        if (found_in || hit) ent_nxt = right_ent;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_q = ent_r;

endmodule

`default_nettype wire

/* rtl/core/sorted_timer_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_timer_queue_core: timer table kept sorted in a chain of cells
// Setup, cancel and tick commands; ticks fire due entries in order and
// reinsert periodic ones.
// ----------------------------------------------------------------------------
// Each command's first result word is registered in S_EXEC or S_FIRE, the
// state entered on acceptance. Tick: fired words follow one per cycle (one
//   head pop per cycle) while the output is free, then the periodic ones
//   are reinserted in S_REINS. A new command is taken only in S_IDLE.
// Output stalls hold S_EXEC and S_FIRE; S_REINS does not wait on them.
// Reset (synchronous, rst_n low): time, id counter and all slots cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_queue_core
  import stq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  stq_in_if.sink     in_ch,
  stq_out_if.source  out_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FIRE  = 2'd2;
  localparam logic [1:0] S_REINS = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] time_r, time_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] exp_r;
  logic [23:0] per_r;
  logic [15:0] key_r;
  logic [FQ_CW-1:0] fire_cnt_r, fire_cnt_nxt;

  // reinsert queue
  entry_t           fq_mem [FIRE_MAX];
  logic [FQ_AW-1:0] fq_wp_r, fq_rp_r, fq_rp_nxt;
  logic [FQ_CW-1:0] fq_cnt_r, fq_cnt_nxt;
  logic             fq_push, fq_pop;
  entry_t           fq_wdata;
  entry_t           fq_rd_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_id_r;
  logic        out_last_r;
  logic        emit;
  logic [2:0]  emit_status;
  logic [15:0] emit_id;
  logic        emit_last;
  logic        out_free;

  // chain
  chain_ctrl_t ctrl;
  entry_t      cell_q [SLOTS];
  logic [SLOTS:0] found;
  logic [SLOTS-1:0] valid_vec;
  logic        in_acc;
  logic        fire_ok, fire_more;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign found[0] = 1'b0;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t l_ent, r_ent;
    if (i == 0) begin : g_l0
      assign l_ent = '0;
    end else begin : g_l
      assign l_ent = cell_q[i-1];
    end
    if (i == SLOTS - 1) begin : g_rn
      assign r_ent = '0;
    end else begin : g_r
      assign r_ent = cell_q[i+1];
    end
    stq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .ent_q     (cell_q[i])
    );
    assign valid_vec[i] = cell_q[i].valid;
  end

  // head firing tests
  assign fire_ok   = cell_q[0].valid && !earlier(time_r, cell_q[0].expiry);
  assign fire_more = cell_q[1].valid && !earlier(time_r, cell_q[1].expiry) &&
                     (fire_cnt_r != FQ_CW'(FIRE_MAX - 1));
  assign fq_wdata  = '{valid: 1'b1, id: cell_q[0].id,
                       expiry: cell_q[0].expiry + {8'd0, cell_q[0].period},
                       period: cell_q[0].period, periodic: 1'b1};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    time_nxt     = time_r;
    next_id_nxt  = next_id_r;
    fire_cnt_nxt = fire_cnt_r;
    ctrl         = '0;
    ctrl.op      = OP_HOLD;
    emit         = 1'b0;
    emit_status  = ST_QUIET;
    emit_id      = 16'd0;
    emit_last    = 1'b1;
    fq_push      = 1'b0;
    fq_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_TICK) begin
            time_nxt     = time_r + 32'd1;
            fire_cnt_nxt = '0;
            state_nxt    = S_FIRE;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r == CMD_CANCEL) begin
            ctrl.op   = OP_REM;
            ctrl.key  = key_r;
            emit_id   = key_r;
            emit_status = found[SLOTS] ? ST_REMOVED : ST_NOTFOUND;
          end else if (cell_q[SLOTS-1].valid) begin
            emit_status = ST_FULL;
          end else begin
            ctrl.op  = OP_INS;
            ctrl.ent = '{valid: 1'b1, id: next_id_r, expiry: exp_r,
                         period: (cmd_r == CMD_PERIODIC) ? per_r : 24'd0,
                         periodic: (cmd_r == CMD_PERIODIC)};
            emit_status = ST_SETUP;
            emit_id     = next_id_r;
            next_id_nxt = next_id_r + 16'd1;
          end
        end
      end
      S_FIRE: begin
        if (out_free) begin
          emit = 1'b1;
          if (fire_ok) begin
            ctrl.op      = OP_REM;
            ctrl.head    = 1'b1;
            emit_status  = ST_FIRED;
            emit_id      = cell_q[0].id;
            emit_last    = !fire_more;
            fq_push      = cell_q[0].periodic;
            fire_cnt_nxt = fire_cnt_r + FQ_CW'(1);
            if (!fire_more) begin
              state_nxt = (fq_cnt_r != '0 || cell_q[0].periodic) ? S_REINS : S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REINS: begin
        ctrl.op  = OP_INS;
        ctrl.ent = fq_rd_r;
        fq_pop   = 1'b1;
        if (fq_cnt_r == FQ_CW'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign fq_cnt_nxt = fq_cnt_r + FQ_CW'(fq_push) - FQ_CW'(fq_pop);
  assign fq_rp_nxt  = fq_rp_r + FQ_AW'(fq_pop);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      next_id_r   <= '0;
      fire_cnt_r  <= '0;
      fq_wp_r     <= '0;
      fq_rp_r     <= '0;
      fq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      time_r     <= time_nxt;
      next_id_r  <= next_id_nxt;
      fire_cnt_r <= fire_cnt_nxt;
      fq_cnt_r   <= fq_cnt_nxt;
      fq_rp_r    <= fq_rp_nxt;
      if (fq_push) fq_wp_r <= fq_wp_r + FQ_AW'(1);
      if (emit)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers; queue head is prefetched, a same-cycle write bypasses
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_ch.command;
      exp_r <= time_r + {8'd0, in_ch.delay};
      per_r <= (in_ch.interval == 24'd0) ? 24'd1 : in_ch.interval;
      key_r <= in_ch.cancel_id;
    end
    if (fq_push) fq_mem[fq_wp_r] <= fq_wdata;
    if (fq_push && (fq_wp_r == fq_rp_nxt)) fq_rd_r <= fq_wdata;
    else                                   fq_rd_r <= fq_mem[fq_rp_nxt];
    if (emit) begin
      out_status_r <= emit_status;
      out_id_r     <= emit_id;
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.timer_id = out_id_r;
  assign out_ch.last     = out_last_r;

  // checks
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + SLOTS'(1))) == '0)
    else $error("valid slots not a prefix");
  a_fire_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRE) |-> (fire_cnt_r < FQ_CW'(FIRE_MAX)))
    else $error("fire count over limit");
  a_reins_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REINS) |-> (fq_cnt_r != '0))
    else $error("reinsert with empty queue");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fq_cnt_r == '0))
    else $error("reinsert queue left over");

endmodule

`default_nettype wire

/* sim/tb_sorted_timer_queue_core.sv */
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue_core: self-checking bench of the sorted timer queue
// Drives setup, cancel and tick words, keeps its own timer table to predict
// every result word, and compares each accepted result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_timer_queue_core;
  import stq_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] delay;
    logic [23:0] interval;
    logic [15:0] cancel_id;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] timer_id;
    logic        last;
  } res_word_t;

  logic clk;
  logic rst_n;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  sorted_timer_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // predicted timer table
  logic [31:0] now_time;
  logic [15:0] id_ctr;
  int          tbl_n;
  logic [15:0] tbl_id     [SLOTS];
  logic [31:0] tbl_exp    [SLOTS];
  logic [23:0] tbl_per    [SLOTS];
  logic        tbl_pd     [SLOTS];

  cmd_word_t pending_cmds [$];
  res_word_t expected_res [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  bit send_pause;
  int hold_cycles;
  int mismatches;
  int cycle_cnt;

  // append to the tail of the word queues
  function automatic void enq_cmd(input cmd_word_t w);
    pending_cmds.insert(pending_cmds.size(), w);
  endfunction

  function automatic void enq_res(input res_word_t w);
    expected_res.insert(expected_res.size(), w);
  endfunction

  function automatic bit time_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void table_insert(input logic [15:0] id, input logic [31:0] ex,
                                       input logic [23:0] per, input logic pd);
    int pos;
    pos = 0;
    if (tbl_n >= SLOTS) return;
    while (pos < tbl_n && !time_before(ex, tbl_exp[pos])) pos++;
    for (int i = tbl_n; i > pos; i--) begin
      tbl_id[i] = tbl_id[i-1]; tbl_exp[i] = tbl_exp[i-1];
      tbl_per[i] = tbl_per[i-1]; tbl_pd[i] = tbl_pd[i-1];
    end
    tbl_id[pos] = id; tbl_exp[pos] = ex; tbl_per[pos] = per; tbl_pd[pos] = pd;
    tbl_n++;
  endfunction

  function automatic void table_remove(input int pos);
    for (int i = pos; i + 1 < tbl_n; i++) begin
      tbl_id[i] = tbl_id[i+1]; tbl_exp[i] = tbl_exp[i+1];
      tbl_per[i] = tbl_per[i+1]; tbl_pd[i] = tbl_pd[i+1];
    end
    tbl_n--;
  endfunction

  // work out the result words of one accepted command word
  function automatic void predict_timer_results(input cmd_word_t c);
    logic [15:0] f_id  [FIRE_MAX];
    logic [31:0] f_exp [FIRE_MAX];
    logic [23:0] f_per [FIRE_MAX];
    logic        f_pd  [FIRE_MAX];
    int k;
    bit hit;
    k = 0;
    hit = 0;
    case (c.command)
      CMD_ONESHOT, CMD_PERIODIC: begin
        if (tbl_n >= SLOTS) begin
          enq_res('{ST_FULL, 16'd0, 1'b1});
        end else begin
          if (c.command == CMD_PERIODIC)
            table_insert(id_ctr, now_time + c.delay,
                         (c.interval == 0) ? 24'd1 : c.interval, 1'b1);
          else
            table_insert(id_ctr, now_time + c.delay, 24'd0, 1'b0);
          enq_res('{ST_SETUP, id_ctr, 1'b1});
          id_ctr = id_ctr + 16'd1;
        end
      end
      CMD_CANCEL: begin
        for (int i = 0; i < tbl_n && !hit; i++) begin
          if (tbl_id[i] == c.cancel_id) begin
            table_remove(i);
            hit = 1;
          end
        end
        enq_res('{hit ? ST_REMOVED : ST_NOTFOUND, c.cancel_id, 1'b1});
      end
      default: begin
        now_time = now_time + 32'd1;
        while (k < FIRE_MAX && tbl_n > 0 && !time_before(now_time, tbl_exp[0])) begin
          f_id[k] = tbl_id[0]; f_exp[k] = tbl_exp[0];
          f_per[k] = tbl_per[0]; f_pd[k] = tbl_pd[0];
          table_remove(0);
          k++;
        end
        if (k == 0) enq_res('{ST_QUIET, 16'd0, 1'b1});
        for (int j = 0; j < k; j++) begin
          if (f_pd[j]) table_insert(f_id[j], f_exp[j] + f_per[j], f_per[j], 1'b1);
          enq_res('{ST_FIRED, f_id[j], (j == k - 1)});
        end
      end
    endcase
  endfunction

  function automatic cmd_word_t mk(input logic [1:0] cm, input logic [23:0] d,
                                   input logic [23:0] iv, input logic [15:0] cid);
    cmd_word_t w;
    w.command = cm; w.delay = d; w.interval = iv; w.cancel_id = cid;
    return w;
  endfunction

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the offered word
    end else begin
      if (in_ch.valid) begin
        predict_timer_results(pending_cmds.pop_front());
      end
      if (pending_cmds.size() > 0 && !send_pause &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.command   <= pending_cmds[0].command;
        in_ch.delay     <= pending_cmds[0].delay;
        in_ch.interval  <= pending_cmds[0].interval;
        in_ch.cancel_id <= pending_cmds[0].cancel_id;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (recv_hold) begin
      hold_cycles <= hold_cycles + 1;
    end else begin
      hold_cycles <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    res_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_res.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result word: status=%0d id=%0d last=%0d",
                   out_ch.status, out_ch.timer_id, out_ch.last);
      end else begin
        exp_w = expected_res.pop_front();
        if (out_ch.status !== exp_w.status || out_ch.timer_id !== exp_w.timer_id ||
            out_ch.last !== exp_w.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected status=%0d id=%0d last=%0d, got %0d %0d %0d",
                     exp_w.status, exp_w.timer_id, exp_w.last,
                     out_ch.status, out_ch.timer_id, out_ch.last);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("FAIL sorted_timer_queue_core");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_res.size() > 0)
      @(posedge clk);
  endtask

  // random setup/cancel/tick mix
  task automatic add_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99, 0);
      if (r < 25)
        enq_cmd(mk(CMD_ONESHOT,
          ($urandom_range(3, 0) == 0) ? 24'($urandom) : 24'($urandom_range(6, 0)),
          24'($urandom), 16'($urandom)));
      else if (r < 45)
        enq_cmd(mk(CMD_PERIODIC,
          ($urandom_range(3, 0) == 0) ? 24'($urandom) : 24'($urandom_range(5, 0)),
          ($urandom_range(3, 0) == 0) ? 24'($urandom) : 24'($urandom_range(4, 0)),
          16'($urandom)));
      else if (r < 60)
        enq_cmd(mk(CMD_CANCEL, 24'($urandom), 24'($urandom),
          ($urandom_range(3, 0) == 0) ? 16'($urandom) : id_ctr - 16'($urandom_range(8, 0))));
      else
        enq_cmd(mk(CMD_TICK, 24'($urandom), 24'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.command = CMD_TICK; in_ch.delay = '0;
    in_ch.interval = '0; in_ch.cancel_id = '0; out_ch.ready = 1'b0;
    now_time = '0; id_ctr = '0; tbl_n = 0; mismatches = 0; cycle_cnt = 0;
    send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0; send_pause = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed: quiet tick, extremes, cancel hit/miss, zero interval, full table
    enq_cmd(mk(CMD_TICK, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF));
    enq_cmd(mk(CMD_CANCEL, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF));
    enq_cmd(mk(CMD_ONESHOT, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF));
    enq_cmd(mk(CMD_PERIODIC, 24'd0, 24'd0, 16'd0));
    enq_cmd(mk(CMD_PERIODIC, 24'd1, 24'd2, 16'd0));
    enq_cmd(mk(CMD_CANCEL, 24'd0, 24'd0, 16'd0));
    enq_cmd(mk(CMD_ONESHOT, 24'd1, 24'd0, 16'd0));
    for (int i = 0; i < 11; i++)
      enq_cmd(mk(CMD_ONESHOT, 24'd2, 24'd0, 16'd0));
    enq_cmd(mk(CMD_PERIODIC, 24'd3, 24'd1, 16'd0));
    enq_cmd(mk(CMD_ONESHOT, 24'd3, 24'd0, 16'd0));
    enq_cmd(mk(CMD_ONESHOT, 24'd3, 24'd0, 16'd0));
    enq_cmd(mk(CMD_TICK, 24'd0, 24'd0, 16'd0));
    enq_cmd(mk(CMD_TICK, 24'd0, 24'd0, 16'd0));
    enq_cmd(mk(CMD_CANCEL, 24'd0, 24'd0, 16'd2));
    enq_cmd(mk(CMD_TICK, 24'd0, 24'd0, 16'd0));
    wait_drained();

    // receiver holds off while commands keep coming
    send_pause = 1;
    recv_hold = 1;
    send_pause = 0;
    add_random(30);
    while (hold_cycles < 300) @(posedge clk);
    recv_hold = 0;
    wait_drained();

    // idling phases
    send_idle_pct = 34; recv_idle_pct = 68;
    add_random(45);
    wait_drained();
    send_idle_pct = 68; recv_idle_pct = 34;
    add_random(30);
    // sender pause until every result is in
    send_pause = 1;
    while (in_ch.valid || expected_res.size() > 0) @(posedge clk);
    send_pause = 0;
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(30);
    wait_drained();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("PASS sorted_timer_queue_core");
    end else begin
      $display("FAIL sorted_timer_queue_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
